// ===== src/shkm_pkg.sv =====
// Package for the SipHash keyed MAC: initialisation constants, control
// word layout and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package shkm_pkg;

   localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
   localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned ROUND_W = 4;
   localparam int unsigned REQ_W   = 72;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_KEY_LOW   = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH  = 2'd1;
   localparam logic [1:0] CSR_C_ROUNDS  = 2'd2;
   localparam logic [1:0] CSR_F_ROUNDS  = 2'd3;

   // Sequencer step addresses
   localparam logic [1:0] PC_IDLE = 2'd0;
   localparam logic [1:0] PC_COMP = 2'd1;
   localparam logic [1:0] PC_FIN  = 2'd2;
   localparam logic [1:0] PC_OUT  = 2'd3;

   typedef struct packed {
      logic       take_req;   // step accepts a request
      logic       do_round;   // run rounds from the round counter
      logic       mix_out;    // xor block into lane 0 on exit
      logic       branch;     // exit: pad -> pad_pc, final -> fin_pc
      logic       emit;       // load the tag into the output register
      logic [1:0] next_pc;
      logic [1:0] pad_pc;
      logic [1:0] fin_pc;
   } ctl_type;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } lanes_type;

   function automatic ctl_type ucode(input logic [1:0] pc);
      ctl_type c;
      c = '0;
      unique case (pc)
         PC_IDLE: begin
            c.take_req = 1'b1;
            c.next_pc  = PC_COMP;
         end
         PC_COMP: begin
            c.do_round = 1'b1;
            c.mix_out  = 1'b1;
            c.branch   = 1'b1;
            c.pad_pc   = PC_COMP;
            c.fin_pc   = PC_FIN;
            c.next_pc  = PC_IDLE;
         end
         PC_FIN: begin
            c.do_round = 1'b1;
            c.next_pc  = PC_OUT;
         end
         PC_OUT: begin
            c.emit    = 1'b1;
            c.next_pc = PC_IDLE;
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/shkm_round.sv =====
// One SipRound over the four lanes, combinational.
// Depends on shkm_pkg for the lane bundle.
`default_nettype none

module shkm_round
   import shkm_pkg::*;
(
   input  lanes_type lanes_i,
   output lanes_type lanes_o
);

   logic [63:0] a0, a1, a2, a3;
   logic [63:0] b0, b1, b2, b3;

   always_comb begin
      a0 = lanes_i.v0 + lanes_i.v1;
      a2 = lanes_i.v2 + lanes_i.v3;
      a1 = {lanes_i.v1[50:0], lanes_i.v1[63:51]} ^ a0;
      a3 = {lanes_i.v3[47:0], lanes_i.v3[63:48]} ^ a2;
      a0 = {a0[31:0], a0[63:32]};
      b2 = a2 + a1;
      b0 = a0 + a3;
      b1 = {a1[46:0], a1[63:47]} ^ b2;
      b3 = {a3[42:0], a3[63:43]} ^ b0;
      lanes_o.v0 = b0;
      lanes_o.v1 = b1;
      lanes_o.v2 = {b2[31:0], b2[63:32]};
      lanes_o.v3 = b3;
   end

endmodule

`default_nettype wire

// ===== src/siphash_keyed_mac.sv =====
// Top level of the SipHash keyed MAC: config registers, lane datapath and
// microcoded sequencer. Depends on shkm_pkg and shkm_round.
//
// Use: write key_low, key_high, compress_rounds and final_rounds on the csr
// port while idle (reset gives key 0, two and four rounds: SipHash-2-4).
// Send a message as requests on req_: eight little-endian bytes per word,
// req_tlast on the final request with its byte count (0..8). One tag per
// message comes out on rsp_. A request is loaded, then its block runs the
// compress rounds on the single round unit, one SipRound per cycle. The
// last request then runs the final rounds and issues the tag, with a
// further block of compress rounds first when it carries a full word (the
// length block follows). Reset clears the sequencer and starts a new
// message. The tag waits in an output register; while the receiver stalls
// the block still takes and hashes the next message and only holds at the
// point of issuing its tag until the register frees up.
`default_nettype none

module siphash_keyed_mac
   import shkm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // word[63:0], byte_count[67:64], zeros
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [WORD_W-1:0]      rsp_tdata,   // tag[63:0]
   input  wire logic              csr_wen,
   input  wire logic [1:0]        csr_index,
   input  wire logic [WORD_W-1:0] csr_wdata
);

   logic [63:0]        key_low_ff, key_high_ff;
   logic [ROUND_W-1:0] c_rounds_ff, f_rounds_ff;

   lanes_type          lanes_ff, lanes_in, rnd_out, stepped;
   logic [63:0]        blk_ff, blk_in;
   logic [7:0]         len_ff, len_in;
   logic               in_msg_ff, in_msg_in;
   logic               pad_ff, pad_in;
   logic               fin_ff, fin_in;
   logic [ROUND_W-1:0] rcnt_ff, rcnt_in;
   logic [1:0]         pc_ff, pc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   ctl_type            ctl;
   logic               accept, rsp_free, round_on, done;
   logic [COUNT_W-1:0] cnt;
   logic               full;
   logic [63:0]        masked, word;
   logic [7:0]         len_base, len_next;
   lanes_type          init_lanes;

   shkm_round u_round (
      .lanes_i (lanes_ff),
      .lanes_o (rnd_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         c_rounds_ff <= ROUND_W'(2);
         f_rounds_ff <= ROUND_W'(4);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_C_ROUNDS: c_rounds_ff <= csr_wdata[ROUND_W-1:0];
            CSR_F_ROUNDS: f_rounds_ff <= csr_wdata[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   assign ctl        = ucode(pc_ff);
   assign req_tready = ctl.take_req;
   assign accept     = req_tvalid && ctl.take_req;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign round_on   = ctl.do_round && (rcnt_ff != '0);
   assign done       = rcnt_ff <= ROUND_W'(1);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign word = req_tdata[63:0];
   assign cnt  = (req_tdata[67:64] > FULL_COUNT) ? FULL_COUNT : req_tdata[67:64];
   assign full = !req_tlast || (cnt == FULL_COUNT);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (COUNT_W'(i) < cnt) ? word[i*8 +: 8] : 8'h00;
      end
   end

   assign len_base = in_msg_ff ? len_ff : 8'h00;
   assign len_next = full ? len_base + 8'd8 : len_base + {4'h0, cnt};

   assign init_lanes.v0 = key_low_ff ^ SIP_C0;
   assign init_lanes.v1 = key_high_ff ^ SIP_C1;
   assign init_lanes.v2 = key_low_ff ^ SIP_C2;
   assign init_lanes.v3 = key_high_ff ^ SIP_C3;

   assign stepped = round_on ? rnd_out : lanes_ff;

   always_comb begin
      lanes_in     = lanes_ff;
      blk_in       = blk_ff;
      len_in       = len_ff;
      in_msg_in    = in_msg_ff;
      pad_in       = pad_ff;
      fin_in       = fin_ff;
      rcnt_in      = rcnt_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         lanes_in    = in_msg_ff ? lanes_ff : init_lanes;
         blk_in      = full ? word : (masked | {len_next, 56'h0});
         lanes_in.v3 = lanes_in.v3 ^ blk_in;
         len_in      = len_next;
         in_msg_in   = 1'b1;
         pad_in      = req_tlast && full;
         fin_in      = req_tlast;
         rcnt_in     = c_rounds_ff;
         pc_in       = ctl.next_pc;
      end

      if (ctl.do_round) begin
         lanes_in = stepped;
         if (round_on) begin
            rcnt_in = rcnt_ff - ROUND_W'(1);
         end
         if (done) begin
            pc_in = ctl.next_pc;
            if (ctl.mix_out) begin
               lanes_in.v0 = stepped.v0 ^ blk_ff;
            end
            if (ctl.branch && pad_ff) begin
               blk_in      = {len_ff, 56'h0};
               lanes_in.v3 = stepped.v3 ^ blk_in;
               pad_in      = 1'b0;
               rcnt_in     = c_rounds_ff;
               pc_in       = ctl.pad_pc;
            end else if (ctl.branch && fin_ff) begin
               lanes_in.v2 = stepped.v2 ^ SIP_FIN;
               rcnt_in     = f_rounds_ff;
               pc_in       = ctl.fin_pc;
            end
         end
      end

      if (ctl.emit && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = lanes_ff.v0 ^ lanes_ff.v1 ^ lanes_ff.v2 ^ lanes_ff.v3;
         in_msg_in    = 1'b0;
         fin_in       = 1'b0;
         pc_in        = ctl.next_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff    <= 1'b0;
         pad_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         rcnt_ff      <= '0;
         pc_ff        <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         in_msg_ff    <= in_msg_in;
         pad_ff       <= pad_in;
         fin_ff       <= fin_in;
         rcnt_ff      <= rcnt_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff    <= lanes_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== test/siphash_keyed_mac_test.sv =====
// Self-checking testbench for siphash_keyed_mac: directed and random messages,
// key and round settings, random idling on both sides and a long receiver stall.
// Depends on shkm_pkg and the siphash_keyed_mac RTL.
`timescale 1ns / 1ps

module siphash_keyed_mac_test
   import shkm_pkg::*;
();

   localparam int BLOCK_LATENCY = 64;
   localparam int RANDOM_REQUESTS = 1400;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              req_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [WORD_W-1:0] rsp_tdata;
   logic              csr_wen;
   logic [1:0]        csr_index;
   logic [WORD_W-1:0] csr_wdata;

   logic [63:0]  key_lo;
   logic [63:0]  key_hi;
   logic [3:0]   comp_rounds;
   logic [3:0]   fin_rounds;
   lanes_type    mac_lanes;
   logic [7:0]   msg_len;
   bit           msg_open;
   logic [63:0]  expected_tags[$];
   logic [63:0]  want_tag;
   int           mismatches;
   int           requests_sent;
   int           hold_cycles;
   int           pause_left;
   bit           no_idle;

   siphash_keyed_mac u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned b);
      return (x << b) | (x >> (64 - b));
   endfunction

   function automatic lanes_type sip_mix(input lanes_type s, input logic [3:0] n);
      lanes_type t;
      t = s;
      for (int r = 0; r < n; r++) begin
         t.v0 = t.v0 + t.v1;
         t.v2 = t.v2 + t.v3;
         t.v1 = rotl(t.v1, 13);
         t.v3 = rotl(t.v3, 16);
         t.v1 = t.v1 ^ t.v0;
         t.v3 = t.v3 ^ t.v2;
         t.v0 = rotl(t.v0, 32);
         t.v2 = t.v2 + t.v1;
         t.v0 = t.v0 + t.v3;
         t.v1 = rotl(t.v1, 17);
         t.v3 = rotl(t.v3, 21);
         t.v1 = t.v1 ^ t.v2;
         t.v3 = t.v3 ^ t.v0;
         t.v2 = rotl(t.v2, 32);
      end
      return t;
   endfunction

   function automatic lanes_type absorb_block(input lanes_type s, input logic [63:0] m,
                                              input logic [3:0] n);
      lanes_type t;
      t = s;
      t.v3 = t.v3 ^ m;
      t = sip_mix(t, n);
      t.v0 = t.v0 ^ m;
      return t;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // advance the MAC state by one accepted request, queue the tag on a last one
   task automatic hash_request(input logic [63:0] word, input logic [3:0] count,
                               input logic is_last);
      logic [3:0]  n;
      logic [63:0] block;
      if (!msg_open) begin
         mac_lanes.v0 = key_lo ^ SIP_C0;
         mac_lanes.v1 = key_hi ^ SIP_C1;
         mac_lanes.v2 = key_lo ^ SIP_C2;
         mac_lanes.v3 = key_hi ^ SIP_C3;
         msg_len = 8'd0;
         msg_open = 1'b1;
      end
      if (!is_last) begin
         mac_lanes = absorb_block(mac_lanes, word, comp_rounds);
         msg_len = msg_len + 8'd8;
         return;
      end
      n = (count > FULL_COUNT) ? FULL_COUNT : count;
      if (n == FULL_COUNT) begin
         mac_lanes = absorb_block(mac_lanes, word, comp_rounds);
         msg_len = msg_len + 8'd8;
         block = 64'd0;
      end else begin
         block = word & ((64'd1 << (8 * n)) - 64'd1);
         msg_len = msg_len + 8'(n);
      end
      block[63:56] = msg_len;
      mac_lanes = absorb_block(mac_lanes, block, comp_rounds);
      mac_lanes.v2 = mac_lanes.v2 ^ SIP_FIN;
      mac_lanes = sip_mix(mac_lanes, fin_rounds);
      expected_tags.push_back(mac_lanes.v0 ^ mac_lanes.v1 ^ mac_lanes.v2 ^ mac_lanes.v3);
      msg_open = 1'b0;
   endtask

   task automatic send_request(input logic [63:0] word, input logic [3:0] count,
                               input logic is_last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, count, word};
      req_tlast  = is_last;
      do @(posedge clock); while (req_tready !== 1'b1);
      hash_request(word, count, is_last);
      requests_sent++;
   endtask

   // drop the request stream and wait until the block has drained
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (BLOCK_LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wen   = 1'b0;
      case (idx)
         CSR_KEY_LOW:  key_lo = value;
         CSR_KEY_HIGH: key_hi = value;
         CSR_C_ROUNDS: comp_rounds = value[3:0];
         CSR_F_ROUNDS: fin_rounds = value[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] klo, input logic [63:0] khi,
                             input logic [3:0] c, input logic [3:0] f);
      settle();
      write_register(CSR_KEY_LOW, klo);
      write_register(CSR_KEY_HIGH, khi);
      write_register(CSR_C_ROUNDS, {60'd0, c});
      write_register(CSR_F_ROUNDS, {60'd0, f});
   endtask

   task automatic send_message(input int words, input logic [3:0] last_count);
      logic [3:0] count;
      for (int i = 0; i < words; i++) begin
         count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : FULL_COUNT;
         send_request(rand_word(), count, 1'b0);
      end
      send_request(rand_word(), last_count, 1'b1);
   endtask

   task automatic test_reset_defaults();
      send_request(rand_word(), 4'd0, 1'b1);
      send_request('1, FULL_COUNT, 1'b1);
      send_request(64'd0, 4'd3, 1'b0);
      send_request('1, 4'd12, 1'b0);
      send_request(rand_word(), 4'd7, 1'b1);
      send_request('1, 4'd15, 1'b1);
      send_request('1, 4'd1, 1'b1);
   endtask

   task automatic test_sequential_key();
      set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 4'd2, 4'd4);
      send_request(64'h0706050403020100, FULL_COUNT, 1'b0);
      send_request(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
      send_request(64'h0706050403020100, FULL_COUNT, 1'b1);
   endtask

   task automatic test_round_extremes();
      set_config('1, '1, 4'd0, 4'd0);
      send_message(1, 4'd5);
      set_config(64'd0, 64'd0, 4'd15, 4'd15);
      send_message(1, 4'd5);
      set_config(rand_word(), '1, 4'd0, 4'd15);
      send_message(1, 4'd9);
      set_config('1, rand_word(), 4'd15, 4'd0);
      send_message(1, 4'd8);
   endtask

   task automatic test_mid_message_change();
      set_config(rand_word(), rand_word(), 4'd1, 4'd3);
      send_request(rand_word(), FULL_COUNT, 1'b0);
      settle();
      write_register(CSR_C_ROUNDS, 64'd3);
      write_register(CSR_F_ROUNDS, 64'd1);
      write_register(CSR_KEY_LOW, rand_word());
      send_request(rand_word(), FULL_COUNT, 1'b0);
      send_request(rand_word(), 4'd4, 1'b1);
      send_request(rand_word(), 4'd2, 1'b1);
   endtask

   // hold the receiver off while the sender keeps pushing
   task automatic test_back_pressure();
      set_config(rand_word(), rand_word(), 4'd2, 4'd4);
      no_idle = 1'b1;
      @(posedge clock);
      hold_cycles = 1500;
      repeat (6) send_request(rand_word(), 4'($urandom_range(0, 8)), 1'b1);
      no_idle = 1'b0;
   endtask

   task automatic test_random_messages();
      logic [63:0] klo;
      logic [63:0] khi;
      logic [3:0]  c;
      logic [3:0]  f;
      int          words;
      logic [3:0]  last_count;
      while (requests_sent < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 3))
            0: klo = 64'd0;
            1: klo = '1;
            default: klo = rand_word();
         endcase
         case ($urandom_range(0, 3))
            0: khi = 64'd0;
            1: khi = '1;
            default: khi = rand_word();
         endcase
         c = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 4));
         f = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 4));
         set_config(klo, khi, c, f);
         no_idle = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(8, 25)) begin
            words = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
            last_count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
            send_message(words, last_count);
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      pause_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            pause_left = no_idle ? 0 : $urandom_range(0, 14);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else if (pause_left > 0) begin
            rsp_tready = 1'b0;
            pause_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_tags.size() == 0) begin
            $error("tag: no tag expected, actual %h", rsp_tdata);
            mismatches++;
         end else begin
            want_tag = expected_tags.pop_front();
            if (rsp_tdata !== want_tag) begin
               $error("tag: expected %h, actual %h", want_tag, rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("siphash_keyed_mac regression: fail");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_wen     = 1'b0;
      csr_index   = CSR_KEY_LOW;
      csr_wdata   = '0;
      key_lo      = 64'd0;
      key_hi      = 64'd0;
      comp_rounds = 4'd2;
      fin_rounds  = 4'd4;
      mac_lanes   = '0;
      msg_len     = 8'd0;
      msg_open    = 1'b0;
      mismatches  = 0;
      requests_sent = 0;
      hold_cycles = 0;
      no_idle     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_sequential_key();
      test_round_extremes();
      test_mid_message_change();
      test_back_pressure();
      test_random_messages();
      settle();

      if (mismatches == 0)
         $display("siphash_keyed_mac regression: pass");
      else
         $display("siphash_keyed_mac regression: fail");
      $finish;
   end

endmodule
